/* src/aps_pkg.sv */
`default_nettype none

package aps_pkg;

	localparam int unsigned MAX_PROCS = 16;
	localparam int unsigned IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int unsigned CNT_W     = $clog2(MAX_PROCS + 1);

	localparam logic [7:0]  PRIO_MAX = 8'hFF;
	localparam logic [15:0] SKIP_MAX = 16'hFFFF;

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_GRANTED  = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_ADDED    = 2'd2,
		ST_REJECTED = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [7:0]  base;
		logic [7:0]  prio;
		logic [15:0] left;
		logic [15:0] skips;
	} entry_t;

endpackage

`default_nettype wire

/* src/aging_priority_scheduler.sv */
// Aging priority scheduler.
// Input channel s_*: one request per handshake. s_tuser selects add (0) or tick (1);
// s_tdata carries proc_id, base_prio and run_time. Output channel m_*: exactly one
// result per request, status in m_tuser and the grant details in m_tdata.
// The process table lives in one synchronous memory of MAX_PROCS entries, kept packed
// in insertion order, with the fill count in a register.
// An add (or a tick on an empty table) goes from acceptance through the S_RESP state into
// the output register, which raises m_tvalid. A tick on a filled table first makes two
// passes over its used entries and then goes through S_RESP in the same way:
// one read pass over the memory picks the highest current priority (earliest slot wins
// ties), a second read/write pass ages the losers, updates the winner and closes the gap
// when the winner runs out of time. Both passes use the single memory read port.
// One request is in flight at a time; s_tready is high only while the block waits for
// work, and a finished result waits in the output register while the next request is
// taken. If the receiver stalls, the result holds on m_tdata/m_tuser and the next
// result waits until the register is free.
// Reset empties the table at once (fill count cleared); no clearing pass is needed.
`default_nettype none

module aging_priority_scheduler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // proc_id[7:0], base_prio[15:8], run_time[31:16]
	input  wire logic        s_tuser,  // op
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,  // granted_id, prio_at_grant, skips_at_grant,
	                                   // time_left, finished, zero fill
	output logic [1:0]       m_tuser   // status
);
	import aps_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_AGE,
		S_RESP
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic             issue_q;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	entry_t           rdata_s1;
	logic [IDX_W-1:0] win_q;
	entry_t           win_q_ent;
	status_t          res_status_q;
	logic [55:0]      res_data_q;

	entry_t           mem [MAX_PROCS];
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;

	logic [CNT_W-1:0] cnt_m1;
	logic [IDX_W-1:0] last_idx;
	logic             accept;
	logic [7:0]       in_id;
	logic [7:0]       in_base;
	logic [15:0]      in_time;
	logic             add_ok;
	logic [15:0]      win_left_dec;
	logic             win_fin;
	entry_t           aged;
	entry_t           win_upd;
	logic [55:0]      grant_data;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_id    = s_tdata[7:0];
	assign in_base  = s_tdata[15:8];
	assign in_time  = s_tdata[31:16];
	assign add_ok   = (count_q < CNT_W'(MAX_PROCS)) && (in_time != 16'd0);
	assign cnt_m1   = count_q - CNT_W'(1);
	assign last_idx = cnt_m1[IDX_W-1:0];

	assign win_left_dec = win_q_ent.left - {15'd0, (win_q_ent.left != 16'd0)};
	assign win_fin      = (win_left_dec == 16'd0);
	assign grant_data   = {7'd0, win_fin, win_left_dec, win_q_ent.skips, win_q_ent.prio,
	                       win_q_ent.id};

	always_comb begin
		aged       = rdata_s1;
		aged.prio  = (rdata_s1.prio == PRIO_MAX) ? rdata_s1.prio : rdata_s1.prio + 8'd1;
		aged.skips = (rdata_s1.skips == SKIP_MAX) ? rdata_s1.skips : rdata_s1.skips + 16'd1;
		win_upd       = win_q_ent;
		win_upd.prio  = win_q_ent.base;
		win_upd.left  = win_left_dec;
		win_upd.skips = 16'd0;
	end

	// memory write port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = aged;
		if (state_q == S_IDLE) begin
			mem_we          = accept && (s_tuser == OP_ADD) && add_ok;
			mem_waddr       = count_q[IDX_W-1:0];
			mem_wdata.id    = in_id;
			mem_wdata.base  = in_base;
			mem_wdata.prio  = in_base;
			mem_wdata.left  = in_time;
			mem_wdata.skips = 16'd0;
		end else if (state_q == S_AGE && valid_s1) begin
			if (idx_s1 == win_q) begin
				mem_we    = !win_fin;
				mem_wdata = win_upd;
			end else begin
				mem_we = 1'b1;
				if (win_fin && idx_s1 > win_q) begin
					mem_waddr = idx_s1 - IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			rd_ptr_q     <= '0;
			issue_q      <= 1'b0;
			valid_s1     <= 1'b0;
			idx_s1       <= '0;
			win_q        <= '0;
			win_q_ent    <= '0;
			res_status_q <= ST_EMPTY;
			res_data_q   <= '0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
			m_tuser      <= '0;
		end else begin
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			valid_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_data_q <= '0;
						state_q    <= S_RESP;
						if (s_tuser == OP_ADD) begin
							if (add_ok) begin
								res_status_q <= ST_ADDED;
								count_q      <= count_q + CNT_W'(1);
							end else begin
								res_status_q <= ST_REJECTED;
							end
						end else if (count_q == '0) begin
							res_status_q <= ST_EMPTY;
						end else begin
							rd_ptr_q <= '0;
							issue_q  <= 1'b1;
							state_q  <= S_SCAN;
						end
					end
				end
				S_SCAN, S_AGE: begin
					if (issue_q) begin
						valid_s1 <= 1'b1;
						idx_s1   <= rd_ptr_q;
						if (rd_ptr_q == last_idx) begin
							issue_q <= 1'b0;
						end else begin
							rd_ptr_q <= rd_ptr_q + IDX_W'(1);
						end
					end
					if (state_q == S_SCAN) begin
						if (valid_s1 && (idx_s1 == '0 || rdata_s1.prio > win_q_ent.prio)) begin
							win_q     <= idx_s1;
							win_q_ent <= rdata_s1;
						end
						if (valid_s1 && idx_s1 == last_idx) begin
							rd_ptr_q <= '0;
							issue_q  <= 1'b1;
							state_q  <= S_AGE;
						end
					end else if (valid_s1 && idx_s1 == last_idx) begin
						res_status_q <= ST_GRANTED;
						res_data_q   <= grant_data;
						if (win_fin) begin
							count_q <= cnt_m1;
						end
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= res_data_q;
						m_tuser  <= res_status_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PROCS))
		else $error("fill count above table size");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == OP_ADD && add_ok) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("accepted add did not grow the table");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q == S_AGE) |-> ({1'b0, mem_waddr} < {1'b0, count_q}))
		else $error("write beyond used entries");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!valid_s1 && !issue_q))
		else $error("memory pass active while idle");

	a_tick_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == OP_TICK && count_q != '0) |=> (state_q == S_SCAN))
		else $error("tick on a filled table did not start a scan");
`endif

endmodule

`default_nettype wire

/* test/aging_priority_scheduler_tb.sv */
`timescale 1ns / 1ps

module aging_priority_scheduler_tb;
	import aps_pkg::*;

	localparam longint unsigned CYCLE_LIMIT = 4_000_000;
	localparam int unsigned TICK_DRAIN = 2 * MAX_PROCS + 8;

	typedef struct packed {
		status_t     status;
		logic [7:0]  id;
		logic [7:0]  prio;
		logic [15:0] skips;
		logic [15:0] left;
		logic        finished;
	} grant_t;

	class sched_board;
		entry_t proc_table[$];
		grant_t outstanding_grants[$];
		int unsigned mismatches;

		function void note_request(op_t op, logic [7:0] id, logic [7:0] base,
				logic [15:0] run_time);
			grant_t r;
			entry_t e;
			int win;
			r = '0;
			if (op == OP_ADD) begin
				if (proc_table.size() >= MAX_PROCS || run_time == '0) begin
					r.status = ST_REJECTED;
				end else begin
					e.id = id;
					e.base = base;
					e.prio = base;
					e.left = run_time;
					e.skips = '0;
					proc_table.push_back(e);
					r.status = ST_ADDED;
				end
			end else if (proc_table.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				win = 0;
				foreach (proc_table[k])
					if (proc_table[k].prio > proc_table[win].prio)
						win = k;
				// every loser ages, both counters saturating
				foreach (proc_table[k]) begin
					if (k != win) begin
						e = proc_table[k];
						if (e.prio != PRIO_MAX)
							e.prio = e.prio + 8'd1;
						if (e.skips != SKIP_MAX)
							e.skips = e.skips + 16'd1;
						proc_table[k] = e;
					end
				end
				e = proc_table[win];
				r.status = ST_GRANTED;
				r.id = e.id;
				r.prio = e.prio;
				r.skips = e.skips;
				r.left = e.left - 16'd1;
				if (r.left == '0) begin
					r.finished = 1'b1;
					proc_table.delete(win);
				end else begin
					e.left = r.left;
					e.prio = e.base;
					e.skips = '0;
					proc_table[win] = e;
				end
			end
			outstanding_grants.push_back(r);
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			if (mismatches < 100)
				$display("mismatch on %0s: got %0h, expected %0h", what, got, want);
			mismatches++;
		endtask

		task check_result(logic [1:0] status, logic [55:0] data);
			grant_t g;
			if (outstanding_grants.size() == 0) begin
				report_mismatch("result with no request outstanding", 64'(data), '0);
				return;
			end
			g = outstanding_grants.pop_front();
			if (status !== g.status)
				report_mismatch("status", 64'(status), 64'(g.status));
			if (data[7:0] !== g.id)
				report_mismatch("granted_id", 64'(data[7:0]), 64'(g.id));
			if (data[15:8] !== g.prio)
				report_mismatch("prio_at_grant", 64'(data[15:8]), 64'(g.prio));
			if (data[31:16] !== g.skips)
				report_mismatch("skips_at_grant", 64'(data[31:16]), 64'(g.skips));
			if (data[47:32] !== g.left)
				report_mismatch("time_left", 64'(data[47:32]), 64'(g.left));
			if (data[48] !== g.finished)
				report_mismatch("finished", 64'(data[48]), 64'(g.finished));
			if (data[55:49] !== '0)
				report_mismatch("fill bits", 64'(data[55:49]), '0);
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // proc_id, base_prio, run_time
	logic        s_tuser;  // op
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;  // granted_id, prio_at_grant, skips_at_grant, time_left, finished
	logic [1:0]  m_tuser;  // status

	int unsigned send_idle;
	int unsigned stall_pct;
	longint unsigned cycles;
	sched_board board = new();

	aging_priority_scheduler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("aging_priority_scheduler regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tuser, m_tdata);
		m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
	end

	task automatic send_request(op_t op, logic [7:0] id, logic [7:0] base,
			logic [15:0] run_time);
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {run_time, base, id};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_request(op, id, base, run_time);
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (board.outstanding_grants.size() != 0);
	endtask

	task automatic run_random(int unsigned count);
		int unsigned add_bias;
		logic [7:0] base;
		logic [15:0] run_time;
		add_bias = 50;
		for (int unsigned n = 0; n < count; n++) begin
			// bursts lean towards filling or draining the table
			if (n % 40 == 0)
				add_bias = $urandom_range(25, 80);
			case ($urandom_range(2))
				0: base = 8'($urandom);
				1: base = 8'($urandom_range(250, 255));
				default: base = 8'($urandom_range(0, 3));
			endcase
			case ($urandom_range(49))
				0: run_time = '0;
				1: run_time = 16'($urandom);
				2, 3, 4, 5, 6, 7: run_time = 16'($urandom_range(7, 40));
				default: run_time = 16'($urandom_range(1, 6));
			endcase
			if ($urandom_range(99) < add_bias)
				send_request(OP_ADD, 8'($urandom), base, run_time);
			else
				send_request(OP_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = OP_ADD;
		s_tdata = '0;
		m_tready = 1'b0;
		send_idle = 0;
		stall_pct = 0;
		cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_TICK, 8'hFF, 8'hFF, 16'hFFFF);
		send_request(OP_ADD, 8'hFF, 8'hFF, 16'h0000);

		// first entry always wins ties, the second stays pinned at the priority limit
		send_request(OP_ADD, 8'hA5, 8'hFF, 16'h0004);
		send_request(OP_ADD, 8'h5A, 8'hFF, 16'h0001);
		send_request(OP_ADD, 8'h00, 8'h00, 16'h0003);
		for (int unsigned n = 0; n < 8; n++)
			send_request(OP_TICK, 8'h00, 8'h00, 16'h0000);
		send_request(OP_TICK, 8'h00, 8'h00, 16'h0000);

		// fill to capacity with ties and duplicate ids, then one add too many
		for (int unsigned k = 0; k < MAX_PROCS; k++)
			send_request(OP_ADD, (k == 1) ? 8'hFF : 8'(k * 17),
				(k % 4 == 0) ? 8'hFF : ((k % 4 == 1) ? 8'h00 : 8'h80),
				16'(1 + k % 3));
		send_request(OP_ADD, 8'h33, 8'hFF, 16'h0005);
		send_request(OP_TICK, 8'h00, 8'h00, 16'h0000);
		send_request(OP_TICK, 8'h00, 8'h00, 16'h0000);
		wait_drain();

		run_random(138);
		wait_drain();
		send_idle = 84;
		run_random(138);
		wait_drain();
		send_idle = 0;
		stall_pct <= 84;
		run_random(137);
		wait_drain();
		send_idle = 20;
		stall_pct <= 20;
		run_random(137);
		wait_drain();

		repeat (TICK_DRAIN) @(posedge clk);
		if (board.mismatches == 0 && board.outstanding_grants.size() == 0)
			$display("aging_priority_scheduler regression: pass");
		else
			$display("aging_priority_scheduler regression: fail");
		$finish;
	end

endmodule
